@@ design/bwts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler package
// Shared codes, widths and types for the texture sampler core.
// ----------------------------------------------------------------------------
package bwts_pkg;

    // Item function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_TEX_WIDTH  = 1'b0;
    localparam logic REG_TEX_HEIGHT = 1'b1;

    // Field widths.
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned TEXEL_W = 8;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 9;

    // Result queue depth and its pointer width.
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = 2;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [TEXEL_W-1:0]       t_texel;
    typedef logic [SIZE_W-1:0]        t_size;
    typedef logic [FRAC_W+SIZE_W-1:0] t_scaled;
    typedef logic [OUT_W-1:0]         t_out;

endpackage : bwts_pkg
`default_nettype wire

@@ design/bilinear_wrap_texture_sampler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted sample passes stage 1, stage 2, stage 3 and the sequencer, then the read
// register, the row sums, the vertical blend register and the result queue behind o_valid.
// Port use: each sample makes four texel reads through the single port of the texture
// memory and a load makes one write; stages 1 to 3 can take new items while it reads.
// Reset: synchronous, active low; it clears all valid flags, counters and the size
// registers. The texture memory holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler core
// Stores an 8-bit height map in a single-ported memory and blends four texels
// with repeat addressing for each sample, giving a Q8.8 result.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_core #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration write port.
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [bwts_pkg::CFG_W-1:0]    i_cfg_data,
    // Input channel.
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_func,
    input  wire [bwts_pkg::ADDR_W-1:0]   i_texel_addr,
    input  wire [bwts_pkg::TEXEL_W-1:0]  i_texel_value,
    input  wire [bwts_pkg::COORD_W-1:0]  i_coord_u,
    input  wire [bwts_pkg::COORD_W-1:0]  i_coord_v,
    // Output channel.
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [bwts_pkg::OUT_W-1:0]   o_height_value
);
    import bwts_pkg::*;

    // The size registers are 9 bits wide, so a limit above 511 never clamps.
    localparam int unsigned W_LIM_I = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int unsigned H_LIM_I = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam t_size       W_LIM   = t_size'(W_LIM_I);
    localparam t_size       H_LIM   = t_size'(H_LIM_I);
    localparam logic [SIZE_W-1:0] ONE_256 = SIZE_W'(256);

    // ------------------------------------------------------------------------
    // Configuration registers. The user must change them only while the block is
    // idle, which the block itself does not enforce; every stage reads the clamped sizes directly.
    // ------------------------------------------------------------------------
    t_size r_tex_width;
    t_size r_tex_height;
    t_size w_eff;
    t_size h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= '0;
            r_tex_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                REG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (r_tex_width  > W_LIM) ? W_LIM : r_tex_width;
    assign h_eff = (r_tex_height > H_LIM) ? H_LIM : r_tex_height;

    // ------------------------------------------------------------------------
    // Front pipeline. Stage 1 holds the accepted transaction, stage 2 the
    // scaled coordinates, stage 3 the texel columns, row bases and weights.
    // Each stage moves when the next one is empty or moving.
    // ------------------------------------------------------------------------
    logic               r_s1_vld;
    logic               r_s1_func;
    t_addr              r_s1_addr;
    t_texel             r_s1_value;
    logic [FRAC_W-1:0]  r_s1_ufrac;
    logic [FRAC_W-1:0]  r_s1_vfrac;

    logic               r_s2_vld;
    logic               r_s2_func;
    t_addr              r_s2_addr;
    t_texel             r_s2_value;
    t_scaled            r_s2_fx;
    t_scaled            r_s2_fy;
    logic               r_s2_zero;

    logic               r_s3_vld;
    logic               r_s3_func;
    t_addr              r_s3_addr;
    t_texel             r_s3_value;
    t_addr              r_s3_row0;
    t_addr              r_s3_row1;
    t_size              r_s3_x0;
    t_size              r_s3_x1;
    t_texel             r_s3_tx;
    t_texel             r_s3_ty;
    logic               r_s3_zero;

    // Sequencer stage: owns the memory port.
    logic               r_sq_vld;
    logic               r_sq_func;
    t_addr              r_sq_addr;
    t_texel             r_sq_value;
    t_addr              r_sq_row0;
    t_addr              r_sq_row1;
    t_size              r_sq_x0;
    t_size              r_sq_x1;
    t_texel             r_sq_tx;
    t_texel             r_sq_ty;
    logic               r_sq_zero;
    logic [1:0]         r_sq_phase;

    logic               sq_free;
    logic               sq_done;
    logic               s3_free;
    logic               s2_free;
    logic               s1_free;
    logic               in_fire;

    // Stage 2 to 3 math.
    t_size              s2_x0;
    t_size              s2_y0;
    t_size              s2_x1;
    t_size              s2_y1;
    logic [2*SIZE_W-1:0] s2_row0;
    logic [2*SIZE_W-1:0] s2_row1;

    assign s3_free = !r_s3_vld || sq_free;
    assign s2_free = !r_s2_vld || s3_free;
    assign s1_free = !r_s1_vld || s2_free;
    assign o_ready = s1_free;
    assign in_fire = i_valid && o_ready;

    // Only the fraction of each coordinate matters under repeat addressing;
    // the low 16 bits of a two's complement Q16.16 value are that fraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= i_valid;
        end
        if (in_fire) begin
            r_s1_func  <= i_func;
            r_s1_addr  <= i_texel_addr;
            r_s1_value <= i_texel_value;
            r_s1_ufrac <= i_coord_u[FRAC_W-1:0];
            r_s1_vfrac <= i_coord_v[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_free) begin
            r_s2_vld <= r_s1_vld;
        end
        if (s2_free && r_s1_vld) begin
            r_s2_func  <= r_s1_func;
            r_s2_addr  <= r_s1_addr;
            r_s2_value <= r_s1_value;
            r_s2_fx    <= t_scaled'(r_s1_ufrac) * t_scaled'(w_eff);
            r_s2_fy    <= t_scaled'(r_s1_vfrac) * t_scaled'(h_eff);
            r_s2_zero  <= (w_eff == '0) || (h_eff == '0);
        end
    end

    // The texel index is the integer part of fraction times size; the next
    // column and row wrap back to zero at the texture edge.
    assign s2_x0   = r_s2_fx[FRAC_W +: SIZE_W];
    assign s2_y0   = r_s2_fy[FRAC_W +: SIZE_W];
    assign s2_x1   = (s2_x0 + t_size'(1) == w_eff) ? '0 : s2_x0 + t_size'(1);
    assign s2_y1   = (s2_y0 + t_size'(1) == h_eff) ? '0 : s2_y0 + t_size'(1);
    assign s2_row0 = (2*SIZE_W)'(s2_y0) * (2*SIZE_W)'(w_eff);
    assign s2_row1 = (2*SIZE_W)'(s2_y1) * (2*SIZE_W)'(w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (s3_free) begin
            r_s3_vld <= r_s2_vld;
        end
        if (s3_free && r_s2_vld) begin
            r_s3_func  <= r_s2_func;
            r_s3_addr  <= r_s2_addr;
            r_s3_value <= r_s2_value;
            r_s3_row0  <= s2_row0[ADDR_W-1:0];
            r_s3_row1  <= s2_row1[ADDR_W-1:0];
            r_s3_x0    <= s2_x0;
            r_s3_x1    <= s2_x1;
            r_s3_tx    <= r_s2_fx[8 +: TEXEL_W];
            r_s3_ty    <= r_s2_fy[8 +: TEXEL_W];
            r_s3_zero  <= r_s2_zero;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer. A load writes the memory with a single access. A sample issues four
    // reads in the order top-left, top-right, bottom-left, bottom-right. The
    // first read waits for a free slot in the result queue, so the stages
    // behind the memory never need to stall. Since every memory access goes
    // through this one stage in order, a load is always seen by the samples
    // that follow it and never by those ahead of it.
    // ------------------------------------------------------------------------
    localparam logic [RQ_PTR_W:0] RQ_FULL = (RQ_PTR_W+1)'(RQ_DEPTH);

    logic [RQ_PTR_W:0]  r_credit;
    logic [RQ_PTR_W:0]  n_credit;
    logic               credit_ok;
    logic               rd_issue;
    logic               wr_issue;
    logic               out_pop;
    t_addr              mem_addr;
    t_addr              row_sel;
    t_size              col_sel;

    assign credit_ok = (r_credit != RQ_FULL);
    assign wr_issue  = r_sq_vld && (r_sq_func == FUNC_LOAD);
    assign rd_issue  = r_sq_vld && (r_sq_func == FUNC_SAMPLE)
                       && ((r_sq_phase != 2'd0) || credit_ok);
    assign sq_done   = wr_issue || (rd_issue && (r_sq_phase == 2'd3));
    assign sq_free   = !r_sq_vld || sq_done;

    assign row_sel = r_sq_phase[1] ? r_sq_row1 : r_sq_row0;
    assign col_sel = r_sq_phase[0] ? r_sq_x1   : r_sq_x0;

    always_comb begin
        if (r_sq_func == FUNC_LOAD) begin
            mem_addr = r_sq_addr;
        end else begin
            mem_addr = row_sel + t_addr'(col_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld   <= 1'b0;
            r_sq_phase <= '0;
        end else begin
            if (sq_free) begin
                r_sq_vld <= r_s3_vld;
            end
            if (sq_done) begin
                r_sq_phase <= '0;
            end else if (rd_issue) begin
                r_sq_phase <= r_sq_phase + 2'd1;
            end
        end
        if (sq_free && r_s3_vld) begin
            r_sq_func  <= r_s3_func;
            r_sq_addr  <= r_s3_addr;
            r_sq_value <= r_s3_value;
            r_sq_row0  <= r_s3_row0;
            r_sq_row1  <= r_s3_row1;
            r_sq_x0    <= r_s3_x0;
            r_sq_x1    <= r_s3_x1;
            r_sq_tx    <= r_s3_tx;
            r_sq_ty    <= r_s3_ty;
            r_sq_zero  <= r_s3_zero;
        end
    end

    // Credits count samples that have started reading and not yet left.
    always_comb begin
        n_credit = r_credit;
        if (rd_issue && (r_sq_phase == 2'd0)) begin
            n_credit = n_credit + (RQ_PTR_W+1)'(1);
        end
        if (out_pop) begin
            n_credit = n_credit - (RQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    // ------------------------------------------------------------------------
    // Texture memory: 64K x 8, one port, registered read data.
    // ------------------------------------------------------------------------
    t_texel r_mem [2**ADDR_W];
    t_texel r_mem_q;

    always_ff @(posedge i_clk) begin
        if (wr_issue) begin
            r_mem[mem_addr] <= r_sq_value;
        end
        if (rd_issue) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Blend. Read data is registered and arrives in the cycle after the read; each texel is
    // weighted as it comes in and summed into the top or bottom row value.
    // ------------------------------------------------------------------------
    logic               r_rd_vld;
    logic [1:0]         r_rd_phase;
    t_texel             r_rd_tx;
    t_texel             r_rd_ty;
    logic               r_rd_zero;

    t_out               r_top;
    t_out               r_bot;
    logic               r_ac_vld;
    t_texel             r_ac_ty;
    logic               r_ac_zero;

    t_size              rd_wt;
    t_out               rd_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
        end
        if (rd_issue) begin
            r_rd_phase <= r_sq_phase;
            r_rd_tx    <= r_sq_tx;
            r_rd_ty    <= r_sq_ty;
            r_rd_zero  <= r_sq_zero;
        end
    end

    // The left texel takes 256 - tx, the right one tx; the product stays
    // below 65281 and fits the Q8.8 row value.
    assign rd_wt   = r_rd_phase[0] ? t_size'(r_rd_tx) : ONE_256 - t_size'(r_rd_tx);
    assign rd_prod = t_out'(r_mem_q) * t_out'(rd_wt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac_vld <= 1'b0;
        end else begin
            r_ac_vld <= r_rd_vld && (r_rd_phase == 2'd3);
        end
        if (r_rd_vld) begin
            unique case (r_rd_phase)
                2'd0:    r_top <= rd_prod;
                2'd1:    r_top <= r_top + rd_prod;
                2'd2:    r_bot <= rd_prod;
                default: r_bot <= r_bot + rd_prod;
            endcase
            if (r_rd_phase == 2'd3) begin
                r_ac_ty   <= r_rd_ty;
                r_ac_zero <= r_rd_zero;
            end
        end
    end

    // Vertical blend: both products are registered, then summed and scaled.
    localparam int unsigned PROD_W = OUT_W + SIZE_W;

    logic               r_fn_vld;
    logic [PROD_W-1:0]  r_fn_pa;
    logic [PROD_W-1:0]  r_fn_pb;
    logic               r_fn_zero;
    logic [PROD_W-1:0]  fn_sum;
    t_out               fn_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_vld <= 1'b0;
        end else begin
            r_fn_vld <= r_ac_vld;
        end
        if (r_ac_vld) begin
            r_fn_pa   <= PROD_W'(r_top) * PROD_W'(ONE_256 - t_size'(r_ac_ty));
            r_fn_pb   <= PROD_W'(r_bot) * PROD_W'(r_ac_ty);
            r_fn_zero <= r_ac_zero;
        end
    end

    // An empty texture still runs through the reads but gives zero.
    assign fn_sum = r_fn_pa + r_fn_pb;
    assign fn_res = r_fn_zero ? '0 : fn_sum[8 +: OUT_W];

    // ------------------------------------------------------------------------
    // Result queue. Credits keep it from overflowing, so a stalled output never
    // holds up the reads in flight; it can only hold back a sample's first read.
    // ------------------------------------------------------------------------
    t_out               r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_rq_wr;
    logic [RQ_PTR_W-1:0] r_rq_rd;
    logic [RQ_PTR_W:0]   r_rq_cnt;
    logic [RQ_PTR_W:0]   n_rq_cnt;

    assign o_valid        = (r_rq_cnt != '0);
    assign o_height_value = r_rq[r_rq_rd];
    assign out_pop        = o_valid && i_ready;

    always_comb begin
        n_rq_cnt = r_rq_cnt;
        if (r_fn_vld) begin
            n_rq_cnt = n_rq_cnt + (RQ_PTR_W+1)'(1);
        end
        if (out_pop) begin
            n_rq_cnt = n_rq_cnt - (RQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= '0;
            r_rq_rd  <= '0;
            r_rq_cnt <= '0;
        end else begin
            r_rq_cnt <= n_rq_cnt;
            if (r_fn_vld) begin
                r_rq_wr <= r_rq_wr + RQ_PTR_W'(1);
            end
            if (out_pop) begin
                r_rq_rd <= r_rq_rd + RQ_PTR_W'(1);
            end
        end
        if (r_fn_vld) begin
            r_rq[r_rq_wr] <= fn_res;
        end
    end

endmodule : bilinear_wrap_texture_sampler_core
`default_nettype wire

@@ tb/bilinear_wrap_texture_sampler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler core testbench
// Loads height maps through the input channel, samples them at wrapped
// coordinates and checks every Q8.8 result against a shadow texture and an
// independent bilinear predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_core_tb;

    import bwts_pkg::*;

    localparam int unsigned TEX_MAX_W     = 256;
    localparam int unsigned TEX_MAX_H     = 256;
    localparam int unsigned TARGET_ITEMS  = 1950;
    localparam int unsigned PHASE_ITEMS   = 140;
    // A load passes stages 1, 2 and 3 before it reaches the memory port, so
    // this many quiet cycles let any load still in flight retire.
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES   = 30;

    typedef enum bit {VEC_ITEM, VEC_SIZE} t_vec_kind;

    typedef struct {
        t_vec_kind   kind;
        logic        func;
        t_addr       addr;
        t_texel      value;
        logic [31:0] u;
        logic [31:0] v;
        bit          known;
        t_out        height;
        t_size       w;
        t_size       h;
    } t_stim_vec;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_func;
    t_addr              i_texel_addr;
    t_texel             i_texel_value;
    logic [COORD_W-1:0] i_coord_u;
    logic [COORD_W-1:0] i_coord_v;
    logic               o_valid;
    logic               i_ready;
    t_out               o_height_value;

    // Shadow of the texture memory and of the size registers.
    logic [7:0]  tex_shadow [0:65535];
    bit          tex_loaded [0:65535];
    t_size       shadow_w;
    t_size       shadow_h;

    t_out        pending_heights [$];
    t_stim_vec   directed_vectors [$];
    int unsigned items_sent = 0;
    int unsigned fail_cnt   = 0;
    bit          calm       = 1'b0;

    bilinear_wrap_texture_sampler_core #(
        .MAX_WIDTH  (TEX_MAX_W),
        .MAX_HEIGHT (TEX_MAX_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_texel_addr   (i_texel_addr),
        .i_texel_value  (i_texel_value),
        .i_coord_u      (i_coord_u),
        .i_coord_v      (i_coord_v),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_height_value (o_height_value)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned eff_size(input t_size s, input int unsigned lim);
        return (s > lim) ? lim : s;
    endfunction

    // Works out the four texel addresses and the blend weights of a sample.
    // Returns zero when the texture is empty and nothing is read.
    function automatic bit texel_footprint(input logic [31:0] u, input logic [31:0] v,
                                           output t_addr a00, output t_addr a10,
                                           output t_addr a01, output t_addr a11,
                                           output int unsigned tx, output int unsigned ty);
        int unsigned w, h, fx, fy, x0, y0, x1, y1;
        w   = eff_size(shadow_w, TEX_MAX_W);
        h   = eff_size(shadow_h, TEX_MAX_H);
        a00 = '0;
        a10 = '0;
        a01 = '0;
        a11 = '0;
        tx  = 0;
        ty  = 0;
        if (w == 0 || h == 0) begin
            return 1'b0;
        end
        // The low half of a Q16.16 coordinate is its wrapped fraction,
        // negative coordinates included.
        fx  = u[15:0] * w;
        fy  = v[15:0] * h;
        x0  = fx >> 16;
        y0  = fy >> 16;
        x1  = (x0 + 1 == w) ? 0 : x0 + 1;
        y1  = (y0 + 1 == h) ? 0 : y0 + 1;
        tx  = (fx >> 8) & 8'hFF;
        ty  = (fy >> 8) & 8'hFF;
        a00 = t_addr'(y0 * w + x0);
        a10 = t_addr'(y0 * w + x1);
        a01 = t_addr'(y1 * w + x0);
        a11 = t_addr'(y1 * w + x1);
        return 1'b1;
    endfunction

    function automatic t_out predict_height(input logic [31:0] u, input logic [31:0] v);
        t_addr       a00, a10, a01, a11;
        int unsigned tx, ty, top, bottom, blend;
        if (!texel_footprint(u, v, a00, a10, a01, a11, tx, ty)) begin
            return '0;
        end
        top    = tex_shadow[a00] * (256 - tx) + tex_shadow[a10] * tx;
        bottom = tex_shadow[a01] * (256 - tx) + tex_shadow[a11] * tx;
        blend  = (top * (256 - ty) + bottom * ty) >> 8;
        return t_out'(blend);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 4))
            0: c[15:0] = 16'h0000;
            1: c[15:0] = 16'hFFFF;
            2: c[31:16] = 16'hFFFF;
            default: ;
        endcase
        return c;
    endfunction

    function automatic void add_item(input logic func, input t_addr addr, input t_texel value,
                                     input logic [31:0] u, input logic [31:0] v,
                                     input bit known, input t_out height);
        t_stim_vec vec;
        vec        = '{kind: VEC_ITEM, default: '0};
        vec.func   = func;
        vec.addr   = addr;
        vec.value  = value;
        vec.u      = u;
        vec.v      = v;
        vec.known  = known;
        vec.height = height;
        directed_vectors = {directed_vectors, vec};
    endfunction

    function automatic void add_size(input t_size w, input t_size h);
        t_stim_vec vec;
        vec      = '{kind: VEC_SIZE, default: '0};
        vec.w    = w;
        vec.h    = h;
        directed_vectors = {directed_vectors, vec};
    endfunction

    // Drives one transaction and holds it until accepted. The shadow state is
    // updated, or the expected height queued, at the accepting edge.
    task automatic send_item(input logic func, input t_addr addr, input t_texel value,
                             input logic [31:0] u, input logic [31:0] v,
                             input bit known, input t_out height);
        int unsigned gap;
        t_out        exp_height;
        i_func        <= func;
        i_texel_addr  <= addr;
        i_texel_value <= value;
        i_coord_u     <= u;
        i_coord_v     <= v;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (func == FUNC_LOAD) begin
            tex_shadow[addr] = value;
            tex_loaded[addr] = 1'b1;
        end else begin
            exp_height = known ? height : predict_height(u, v);
            pending_heights = {pending_heights, exp_height};
        end
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A sample may only touch texels that hold a value, so any of its four
    // texels not loaded yet gets a load of random content first.
    task automatic load_missing_texels(input logic [31:0] u, input logic [31:0] v);
        t_addr       taps [4];
        int unsigned tx, ty;
        if (!texel_footprint(u, v, taps[0], taps[1], taps[2], taps[3], tx, ty)) begin
            return;
        end
        foreach (taps[k]) begin
            if (!tex_loaded[taps[k]]) begin
                send_item(FUNC_LOAD, taps[k], t_texel'($urandom_range(0, 255)),
                          $urandom, $urandom, 1'b0, '0);
            end
        end
    endtask

    task automatic drain(input int unsigned settle);
        i_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_sizes(input t_size w, input t_size h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TEX_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_TEX_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_w = w;
        shadow_h = h;
    endtask

    // Result side: checks each accepted transaction against the oldest
    // expectation and throttles i_ready with runs of random length.
    initial begin
        int unsigned hold;
        int unsigned r;
        bit          ready_mode;
        t_out        exp_height;
        hold       = 0;
        ready_mode = 1'b0;
        i_ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_heights.size() == 0) begin
                    $display("%0t: unexpected height transaction, actual %0d",
                             $time, o_height_value);
                    fail_cnt++;
                end else begin
                    exp_height = pending_heights.pop_front();
                    if (o_height_value !== exp_height) begin
                        $display("%0t: height mismatch, expected %0d, actual %0d",
                                 $time, exp_height, o_height_value);
                        fail_cnt++;
                    end
                end
            end
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    ready_mode = 1'b1;
                    hold = $urandom_range(0, 7);
                end else if (r < 70) begin
                    ready_mode = 1'b0;
                    hold = $urandom_range(0, 2);
                end else if (r < 80) begin
                    ready_mode = 1'b1;
                    hold = $urandom_range(30, 80);
                end else if (r < 95) begin
                    ready_mode = 1'b0;
                    hold = $urandom_range(4, 10);
                end else begin
                    ready_mode = 1'b0;
                    hold = $urandom_range(20, 50);
                end
            end else begin
                hold--;
            end
            i_ready <= ready_mode;
        end
    end

    initial begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned r;
        int unsigned area;
        t_size       w;
        t_size       h;
        logic [31:0] u;
        logic [31:0] v;
        t_stim_vec   vec;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_TEX_WIDTH;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_func        <= FUNC_LOAD;
        i_texel_addr  <= '0;
        i_texel_value <= '0;
        i_coord_u     <= '0;
        i_coord_v     <= '0;
        shadow_w = '0;
        shadow_h = '0;

        // Directed part. Sizes are zero after reset, so samples give zero.
        add_item(FUNC_SAMPLE, 16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '0);
        add_item(FUNC_SAMPLE, 16'hFFFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0);
        // A 2x2 map with wrap in both directions and a negative coordinate.
        add_size(9'd2, 9'd2);
        add_item(FUNC_LOAD, 16'd0, 8'd255, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd1, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd2, 8'd0, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd3, 8'd255, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65280);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'h0000_8000, 32'h0000_0000, 1'b0, '0);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'hFFFF_4000, 32'h0000_C000, 1'b0, '0);
        // Either size at zero means an empty texture.
        add_size(9'd0, 9'd5);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, '0);
        add_size(9'd3, 9'd0);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '0);
        // Oversized registers count as the maximum; corners of a 256x256 map.
        add_size(9'd511, 9'd300);
        add_item(FUNC_LOAD, 16'd0, 8'd255, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd1, 8'd0, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd256, 8'd128, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd257, 8'd255, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd255, 8'd1, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd65280, 8'd254, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_LOAD, 16'd65535, 8'd255, 32'h0, 32'h0, 1'b0, '0);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65280);
        add_item(FUNC_SAMPLE, 16'h0, 8'h0, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_vectors[i]) begin
            vec = directed_vectors[i];
            if (vec.kind == VEC_SIZE) begin
                drain(SETTLE_CYCLES);
                write_sizes(vec.w, vec.h);
            end else begin
                if (vec.func == FUNC_SAMPLE) begin
                    load_missing_texels(vec.u, vec.v);
                end
                send_item(vec.func, vec.addr, vec.value, vec.u, vec.v, vec.known, vec.height);
            end
        end

        // Random part: one size setting per phase, extremes first, then
        // mostly small maps so that loads and samples mix densely.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase)
                0: begin w = 9'd1;   h = 9'd1;   end
                1: begin w = 9'd256; h = 9'd256; end
                2: begin w = 9'd511; h = 9'd511; end
                3: begin w = 9'd0;   h = 9'd7;   end
                4: begin w = 9'd9;   h = 9'd0;   end
                5: begin w = 9'd1;   h = 9'd256; end
                6: begin w = 9'd256; h = 9'd1;   end
                7: begin w = 9'd300; h = 9'd3;   end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        w = t_size'($urandom_range(0, 511));
                        h = t_size'($urandom_range(0, 511));
                    end else begin
                        w = t_size'($urandom_range(1, 16));
                        h = t_size'($urandom_range(1, 16));
                    end
                end
            endcase
            drain(SETTLE_CYCLES);
            write_sizes(w, h);
            calm = ($urandom_range(0, 3) == 0);
            area = eff_size(w, TEX_MAX_W) * eff_size(h, TEX_MAX_H);
            for (int unsigned n = 0; n < PHASE_ITEMS && items_sent < TARGET_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    u = rand_coord();
                    v = rand_coord();
                    load_missing_texels(u, v);
                    send_item(FUNC_SAMPLE, t_addr'($urandom), t_texel'($urandom),
                              u, v, 1'b0, '0);
                end else if (r < 92) begin
                    send_item(FUNC_LOAD,
                              (area == 0) ? t_addr'($urandom)
                                          : t_addr'($urandom_range(0, area - 1)),
                              t_texel'($urandom_range(0, 255)),
                              $urandom, $urandom, 1'b0, '0);
                end else begin
                    send_item(FUNC_LOAD, t_addr'($urandom), t_texel'($urandom_range(0, 255)),
                              $urandom, $urandom, 1'b0, '0);
                end
                // Now and then the sender holds off until every expected result has come back.
                if ($urandom_range(0, 199) == 0) begin
                    drain(0);
                end
            end
            phase++;
        end

        drain(TAIL_CYCLES);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : bilinear_wrap_texture_sampler_core_tb
